// ===== sv/fpadd_pkg.sv =====
// constants and types for the binary32 adder
// no dependencies
package fpadd_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned ExpW  = 8;
	localparam int unsigned FracW = 23;
	localparam int unsigned SigW  = 27;
	localparam logic [ExpW-1:0]  ExpAllOnes = 8'd255;
	localparam logic [WordW-1:0] DefaultNan = 32'h7FC0_0000;
	localparam logic [WordW-1:0] InfBits    = 32'h7F80_0000;
	localparam logic [WordW-1:0] QuietBit   = 32'h0040_0000;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		logic                 special;
		word_t                special_val;
		logic                 sign;
		logic                 sub;
		logic [ExpW-1:0]      exp;
		logic [SigW-1:0]      ma;
		logic [SigW-1:0]      mb;
	} s1_t;

	typedef struct packed {
		logic                 special;
		word_t                special_val;
		logic                 sign;
		logic [ExpW-1:0]      exp;
		logic [SigW:0]        r;
	} s2_t;
endpackage

// ===== sv/fpadd_if.sv =====
// valid/ready channel carrying one binary32 word or a pair
// depends on fpadd_pkg
interface fpadd_in_if;
	logic                    valid;
	logic                    ready;
	fpadd_pkg::word_t        operand_a;
	fpadd_pkg::word_t        operand_b;
	modport source (output valid, operand_a, operand_b, input ready);
	modport sink (input valid, operand_a, operand_b, output ready);
endinterface

interface fpadd_out_if;
	logic                    valid;
	logic                    ready;
	fpadd_pkg::word_t        sum_result;
	modport source (output valid, sum_result, input ready);
	modport sink (input valid, sum_result, output ready);
endinterface

// ===== sv/fpadd_norm.sv =====
// leading-zero normalize and round to nearest even
// depends on fpadd_pkg
module fpadd_norm (
	input  fpadd_pkg::s2_t     s,
	output fpadd_pkg::word_t   res
);
	import fpadd_pkg::*;
	logic [4:0]      lz;
	logic [4:0]      sh;
	logic [9:0]      e;
	logic [SigW-1:0] r;
	logic [23:0]     m;
	logic [24:0]     mr;
	logic [9:0]      ef;
	logic [32:0]     bits;
	always_comb begin
		lz = 5'd26;
		for (int i = 0; i < 27; i++) begin
			if (s.r[i]) lz = 5'(26 - i);
		end
		e = {2'b0, s.exp};
		r = s.r[SigW-1:0];
		if (s.r[SigW]) begin
			r = s.r[SigW:1] | {26'b0, s.r[0]};
			e = e + 10'd1;
			sh = 5'd0;
		end else if ({5'b0, lz} < e) begin
			sh = lz;
		end else begin
			sh = 5'(e - 10'd1);
		end
		r = r << sh;
		e = e - {5'b0, sh};
		m = r[SigW-1:3];
		mr = {1'b0, m} + {24'b0, r[2] & ((|r[1:0]) | m[0])};
		ef = e - 10'd1;
		bits = {ef[8:0], 23'b0} + {8'b0, mr};
		if (bits >= {1'b0, InfBits}) bits = {1'b0, InfBits};
		res = s.special ? s.special_val : {s.sign, bits[30:0]};
	end
endmodule

// ===== sv/single_precision_float_adder.sv =====
// binary32 adder, top level; depends on fpadd_pkg, fpadd_if, fpadd_norm
// Accepts one operand pair per cycle while the output is not stalled and
// presents each sum on the output through a three-stage pipeline (unpack and
// swap, align and add, normalize and round); stalls on the output hold all
// stages without loss.
module single_precision_float_adder (
	input  logic            clk,
	input  logic            arst_n,
	fpadd_in_if.sink        in_ch,
	fpadd_out_if.source     out_ch
);
	import fpadd_pkg::*;
	logic v_s1, v_s2, v_s3, adv;
	s1_t d1, q_s1;
	s2_t d2, q_s2;
	word_t res, res_s3;
	assign adv = !v_s3 || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = v_s3;
	assign out_ch.sum_result = res_s3;

	always_comb begin
		logic [7:0] ea, eb, t;
		logic [23:0] fa, fb;
		logic sa, sb;
		word_t a, b;
		a = in_ch.operand_a; b = in_ch.operand_b;
		ea = a[30:23]; eb = b[30:23];
		sa = a[31]; sb = b[31];
		fa = {|ea, a[22:0]}; fb = {|eb, b[22:0]};
		d1 = '0;
		d1.special = 1'b1;
		if (ea == ExpAllOnes) begin
			if (|a[22:0]) d1.special_val = a | QuietBit;
			else if (eb == ExpAllOnes && |b[22:0]) d1.special_val = b | QuietBit;
			else if (eb == ExpAllOnes && sa != sb) d1.special_val = DefaultNan;
			else d1.special_val = a;
		end else if (eb == ExpAllOnes) begin
			d1.special_val = |b[22:0] ? (b | QuietBit) : b;
		end else if (fa == 0) begin
			d1.special_val = fb == 0 ? {sa & sb, 31'b0} : b;
		end else if (fb == 0) begin
			d1.special_val = a;
		end else begin
			d1.special = 1'b0;
		end
		if (ea == 0) ea = 8'd1;
		if (eb == 0) eb = 8'd1;
		if (ea < eb || (ea == eb && fa < fb)) begin
			d1.sign = sb; d1.exp = eb; d1.ma = {fb, 3'b0}; d1.mb = {fa, 3'b0};
			t = eb - ea;
		end else begin
			d1.sign = sa; d1.exp = ea; d1.ma = {fa, 3'b0}; d1.mb = {fb, 3'b0};
			t = ea - eb;
		end
		d1.sub = sa != sb;
		// shift amount parked in special_val when there is no special case
		if (!d1.special) d1.special_val = {24'b0, t};
	end

	always_comb begin
		logic [7:0] n;
		logic [SigW-1:0] al, lost;
		n = q_s1.special_val[7:0];
		lost = '0;
		if (n >= 8'd27) begin
			al = {26'b0, |q_s1.mb};
		end else begin
			al = q_s1.mb >> n;
			lost = q_s1.mb & ~({SigW{1'b1}} << n);
			al[0] = al[0] | (|lost);
		end
		d2.special = q_s1.special;
		d2.special_val = q_s1.special_val;
		d2.sign = q_s1.sign;
		d2.exp = q_s1.exp;
		d2.r = q_s1.sub ? {1'b0, q_s1.ma} - {1'b0, al} : {1'b0, q_s1.ma} + {1'b0, al};
		if (!q_s1.special && q_s1.sub && d2.r == 0) begin
			d2.special = 1'b1;
			d2.special_val = '0;
		end
	end

	fpadd_norm u_norm (.s(q_s2), .res(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1 <= d1; q_s2 <= d2; res_s3 <= res;
		end
	end
endmodule

// ===== bench/fpadd_bench_if.sv =====
// no extra interfaces are needed here: the bench uses fpadd_in_if and fpadd_out_if
// from the rtl interface file; this file holds the sum predictor package
// depends on fpadd_pkg
package fpadd_sum_pkg;
	import fpadd_pkg::*;

	function automatic logic [31:0] sticky_shift(logic [31:0] v, int unsigned n);
		if (n == 0)
			return v;
		if (n >= 32)
			return {31'd0, v != 0};
		return (v >> n) | {31'd0, (v & ((32'd1 << n) - 1)) != 0};
	endfunction

	function automatic word_t predict_sum(word_t a, word_t b);
		logic [7:0] ea, eb, et;
		logic [31:0] fa, fb, ma, mb, r, m, t, bits;
		logic sa, sb, st;
		int xp;
		ea = a[30:23];
		eb = b[30:23];
		fa = {9'd0, a[22:0]};
		fb = {9'd0, b[22:0]};
		sa = a[31];
		sb = b[31];
		if (ea == ExpAllOnes) begin
			if (fa != 0)
				return a | QuietBit;
			if (eb == ExpAllOnes) begin
				if (fb != 0)
					return b | QuietBit;
				if (sa != sb)
					return DefaultNan;
			end
			return a;
		end
		if (eb == ExpAllOnes)
			return (fb != 0) ? (b | QuietBit) : b;
		ma = (ea != 0) ? (fa | 32'h0080_0000) : fa;
		mb = (eb != 0) ? (fb | 32'h0080_0000) : fb;
		if (ma == 0)
			return (mb == 0) ? {sa & sb, 31'd0} : b;
		if (mb == 0)
			return a;
		if (ea == 0)
			ea = 8'd1;
		if (eb == 0)
			eb = 8'd1;
		if (ea < eb || (ea == eb && ma < mb)) begin
			et = ea; ea = eb; eb = et;
			st = sa; sa = sb; sb = st;
			t = ma; ma = mb; mb = t;
		end
		ma = ma << 3;
		mb = sticky_shift(mb << 3, ea - eb);
		xp = ea;
		if (sa == sb) begin
			r = ma + mb;
			if (r[27]) begin
				r = sticky_shift(r, 1);
				xp++;
			end
		end else begin
			r = ma - mb;
			if (r == 0)
				return '0;
			while (!r[26] && xp > 1) begin
				r = r << 1;
				xp--;
			end
		end
		m = r >> 3;
		if (r[2] && (r[1:0] != 0 || m[0]))
			m++;
		bits = (32'(xp - 1) << 23) + m;
		if (bits >= InfBits)
			bits = InfBits;
		return {sa, 31'd0} | bits;
	endfunction

	class sum_scoreboard;
		word_t pending[$];
		int errors;

		function void note_operands(word_t a, word_t b);
			pending.push_back(predict_sum(a, b));
		endfunction

		function void check_sum(word_t got);
			word_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected sum, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (want !== got) begin
				$display("%0t: sum mismatch, expected %h, actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass
endpackage

// ===== bench/single_precision_float_adder_test.sv =====
// testbench for single_precision_float_adder: directed and random operand pairs,
// sums checked against a predictor; depends on fpadd_pkg, fpadd_if, fpadd_sum_pkg
module single_precision_float_adder_test;
	import fpadd_pkg::*;
	import fpadd_sum_pkg::*;

	localparam int NumRandom = 430;
	localparam int CycleLimit = 200000;

	logic clk;
	logic arst_n;
	logic calm;
	int cycles;
	sum_scoreboard board;
	word_t pair_a[$], pair_b[$];

	fpadd_in_if in_ch();
	fpadd_out_if out_ch();

	single_precision_float_adder dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("FAIL single_precision_float_adder");
				$finish;
			end
		end
	end

	function automatic word_t random_operand();
		word_t w;
		w = $urandom;
		case ($urandom_range(0, 9))
			0: w[30:23] = 8'hFF;
			1: w[30:23] = 8'h00;
			2: w[30:23] = $urandom_range(0, 3) ? 8'h00 : 8'hFF;
			3: w[22:0] = '0;
			default: ;
		endcase
		return w;
	endfunction

	function automatic word_t near_operand(word_t x);
		word_t w;
		w = x;
		w[31] = 1'($urandom_range(0, 1));
		w[30:23] = x[30:23] + 8'($urandom_range(0, 4)) - 8'd2;
		if ($urandom_range(0, 1))
			w[3:0] = 4'($urandom);
		else
			w[22:0] = 23'($urandom);
		return w;
	endfunction

	task automatic add_pair(word_t a, word_t b);
		pair_a.push_back(a);
		pair_b.push_back(b);
	endtask

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			board.check_sum(out_ch.sum_result);

	initial begin
		int gap;
		out_ch.ready <= 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14);
				out_ch.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1;
		end
	end

	task automatic send_all();
		int gap;
		word_t a, b;
		while (pair_a.size() > 0) begin
			a = pair_a.pop_front();
			b = pair_b.pop_front();
			if (!calm && $urandom_range(0, 6) == 0) begin
				gap = $urandom_range(1, 14);
				in_ch.valid <= 0;
				repeat (gap) @(posedge clk);
			end
			in_ch.valid <= 1;
			in_ch.operand_a <= a;
			in_ch.operand_b <= b;
			do @(posedge clk); while (!in_ch.ready);
			board.note_operands(a, b);
		end
		in_ch.valid <= 0;
	endtask

	task automatic drain();
		while (board.pending.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		word_t x;
		board = new();
		calm = 0;
		arst_n = 0;
		in_ch.valid <= 0;
		in_ch.operand_a <= '0;
		in_ch.operand_b <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		add_pair(32'h7FC0_1234, 32'h7F80_0001);
		add_pair(32'h3F80_0000, 32'hFF80_0005);
		add_pair(32'h7F80_0000, 32'hFF80_0000);
		add_pair(32'hFF80_0000, 32'hFF80_0000);
		add_pair(32'h7F80_0000, 32'h4000_0000);
		add_pair(32'h1234_5678, 32'hFF80_0000);
		add_pair(32'h8000_0000, 32'h8000_0000);
		add_pair(32'h8000_0000, 32'h0000_0000);
		add_pair(32'h0000_0000, 32'hC2F6_0000);
		add_pair(32'h3DCC_CCCD, 32'h8000_0000);
		add_pair(32'h3F80_0000, 32'hBF80_0000);
		add_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);
		add_pair(32'hFF7F_FFFF, 32'hF3FF_FFFF);
		add_pair(32'h0000_0001, 32'h0000_0001);
		add_pair(32'h007F_FFFF, 32'h0000_0001);
		add_pair(32'h0080_0000, 32'h8000_0001);
		add_pair(32'h3F80_0000, 32'h3380_0000);
		add_pair(32'h3F80_0001, 32'h3380_0000);
		add_pair(32'h3F80_0000, 32'hB380_0001);
		add_pair(32'h3F80_0000, 32'h0000_0001);
		add_pair(32'h4B7F_FFFF, 32'h3F00_0000);
		add_pair(32'hFFFF_FFFF, 32'h0000_0000);
		send_all();
		drain();

		for (int i = 0; i < NumRandom; i++) begin
			if (i == NumRandom * 3 / 4) begin
				send_all();
				drain();
				calm = 1;
			end
			x = random_operand();
			add_pair(x, $urandom_range(0, 2) ? near_operand(x) : random_operand());
		end
		send_all();
		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("PASS single_precision_float_adder");
		else
			$display("FAIL single_precision_float_adder");
		$finish;
	end
endmodule
